// ----- rtl/srwt_pkg.sv -----
package srwt_pkg;

  localparam int PTR_W     = 8;
  localparam int BUF_DEPTH = 1 << PTR_W;
  localparam int SEQ_W     = 32;
  localparam int ACT_W     = 3;
  localparam int SIZE_W    = 9;
  localparam int WIN_W     = 8;

  localparam int INIT_WINDOW  = 16;
  localparam int WIN_LIMIT_RST = 16;

  // lowest-lost search: groups of GRP_SIZE bits, then a pick over NUM_GRP groups
  localparam int GRP_W    = 4;
  localparam int GRP_SIZE = 1 << GRP_W;
  localparam int NUM_GRP  = BUF_DEPTH / GRP_SIZE;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;
  localparam int ADDR_W     = 3;
  localparam int BUS_W      = 32;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_RECV    = 3'd0,
    ACT_CONFIRM = 3'd1,
    ACT_LOST    = 3'd2,
    ACT_REALIGN = 3'd3,
    ACT_SHRINK  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    OC_IN_ORDER = 3'd0,
    OC_HOLE     = 3'd1,
    OC_GAP      = 3'd2,
    OC_STALE    = 3'd3,
    OC_NONE     = 3'd4
  } outcome_t;

  typedef enum logic {
    REG_SEQ_GAP      = 1'b0,
    REG_WINDOW_LIMIT = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_gap;
    logic [WIN_W-1:0] window_limit;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan1;
    logic scan2;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // index of lowest set bit; used for both levels since NUM_GRP equals GRP_SIZE
  function automatic logic [GRP_W-1:0] lowest_set(input logic [GRP_SIZE-1:0] v);
    logic [GRP_W-1:0] r;
    r = '0;
    for (int k = GRP_SIZE - 1; k >= 0; k--) begin
      if (v[k]) begin
        r = GRP_W'(k);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/srwt_regs.sv -----
module srwt_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [srwt_pkg::ADDR_W-1:0] paddr,
  input  logic [srwt_pkg::BUS_W-1:0]  pwdata,
  output logic [srwt_pkg::BUS_W-1:0]  prdata,
  output logic                       pready,
  output srwt_pkg::cfg_t             cfg
);
  import srwt_pkg::*;

  logic     wr_en;
  reg_sel_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign sel    = reg_sel_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seq_gap      <= '0;
      cfg.window_limit <= WIN_W'(WIN_LIMIT_RST);
    end else if (wr_en) begin
      unique case (sel)
        REG_SEQ_GAP:      cfg.seq_gap      <= pwdata;
        REG_WINDOW_LIMIT: cfg.window_limit <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_SEQ_GAP:      prdata = cfg.seq_gap;
      REG_WINDOW_LIMIT: prdata = {{(BUS_W-WIN_W){1'b0}}, cfg.window_limit};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/srwt_ctrl.sv -----
module srwt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  srwt_pkg::dp_status_t   status,
  output srwt_pkg::ctrl_cmd_t    cmd
);
  import srwt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCAN1 = 5'b00100,
    ST_SCAN2 = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_SCAN1;
      end
      ST_SCAN1: begin
        cmd.scan1  = 1'b1;
        state_next = ST_SCAN2;
      end
      ST_SCAN2: begin
        cmd.scan2  = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (!status.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/srwt_dp.sv -----
module srwt_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  srwt_pkg::cfg_t                  cfg,
  input  srwt_pkg::ctrl_cmd_t             cmd,
  output srwt_pkg::dp_status_t            status,
  input  logic [srwt_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [srwt_pkg::ACT_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [srwt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]                      m_tuser
);
  import srwt_pkg::*;

  // captured item
  logic [ACT_W-1:0]  it_act;
  logic [SEQ_W-1:0]  it_seq;
  ptr_t              it_slot;
  logic [SIZE_W-1:0] it_size;
  ptr_t              it_idx;

  // window state
  ptr_t             next_pos, end_pos, start_pos;
  logic [SEQ_W-1:0] expected_seq;
  logic [BUF_DEPTH-1:0] lost_map;
  outcome_t         outcome;

  ptr_t             next_pos_next, end_pos_next, start_pos_next;
  logic [SEQ_W-1:0] expected_seq_next;
  logic [BUF_DEPTH-1:0] set_mask, clr_mask, gap_mask, hit_idx, hit_slot;
  outcome_t         outcome_next;

  ptr_t gap_span, shrink_target, shrink_dif;

  // search
  logic [NUM_GRP-1:0]            grp_any;
  logic [NUM_GRP-1:0][GRP_W-1:0] grp_low;
  logic [GRP_W-1:0]              grp_sel;
  logic                          low_found;
  ptr_t                          low_idx;

  ptr_t             send_slot_c;
  logic [SEQ_W-1:0] ack_c;

  assign status.out_busy = m_tvalid & ~m_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_act  <= s_tuser;
      it_seq  <= s_tdata[SEQ_W-1:0];
      it_slot <= s_tdata[SEQ_W +: PTR_W];
      it_size <= s_tdata[SEQ_W+PTR_W +: SIZE_W];
      it_idx  <= s_tdata[PTR_W-1:0] - cfg.seq_gap[PTR_W-1:0];
    end
  end

  assign gap_span      = it_idx - next_pos;
  assign shrink_target = start_pos + it_size[PTR_W-1:0];
  assign shrink_dif    = end_pos - shrink_target;
  assign hit_idx       = BUF_DEPTH'(1) << it_idx;
  assign hit_slot      = BUF_DEPTH'(1) << it_slot;

  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      gap_mask[i] = (ptr_t'(i) - next_pos) < gap_span;
    end
  end

  always_comb begin
    next_pos_next     = next_pos;
    end_pos_next      = end_pos;
    start_pos_next    = start_pos;
    expected_seq_next = expected_seq;
    set_mask          = '0;
    clr_mask          = '0;
    outcome_next      = OC_NONE;
    unique case (it_act)
      ACT_RECV: begin
        if (it_seq == expected_seq) begin
          next_pos_next     = next_pos + 1'b1;
          end_pos_next      = end_pos + 1'b1;
          expected_seq_next = it_seq + 1'b1;
          outcome_next      = OC_IN_ORDER;
        end else if (lost_map[it_idx]) begin
          clr_mask     = hit_idx;
          outcome_next = OC_HOLE;
        end else if (it_seq > expected_seq) begin
          set_mask          = gap_mask;
          next_pos_next     = it_idx + 1'b1;
          end_pos_next      = it_idx + cfg.window_limit + 1'b1;
          expected_seq_next = it_seq + 1'b1;
          outcome_next      = OC_GAP;
        end else begin
          outcome_next = OC_STALE;
        end
      end
      ACT_CONFIRM: begin
        if (it_slot == next_pos) begin
          next_pos_next     = next_pos + 1'b1;
          expected_seq_next = expected_seq + 1'b1;
        end else begin
          clr_mask = hit_slot;
        end
      end
      ACT_LOST:    set_mask = hit_slot;
      ACT_REALIGN: start_pos_next = low_found ? low_idx : next_pos;
      ACT_SHRINK: begin
        if (shrink_dif > cfg.window_limit) begin
          end_pos_next = shrink_target;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_pos     <= '0;
      end_pos      <= PTR_W'(INIT_WINDOW);
      start_pos    <= '0;
      expected_seq <= '0;
      lost_map     <= '0;
    end else if (cmd.exec) begin
      next_pos     <= next_pos_next;
      end_pos      <= end_pos_next;
      start_pos    <= start_pos_next;
      expected_seq <= expected_seq_next;
      lost_map     <= (lost_map | set_mask) & ~clr_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      outcome <= outcome_next;
    end
  end

  // lowest lost slot, two registered levels; holds between items
  always_ff @(posedge clk) begin
    if (cmd.scan1) begin
      for (int g = 0; g < NUM_GRP; g++) begin
        grp_any[g] <= |lost_map[g*GRP_SIZE +: GRP_SIZE];
        grp_low[g] <= lowest_set(lost_map[g*GRP_SIZE +: GRP_SIZE]);
      end
    end
  end

  assign grp_sel = lowest_set(grp_any);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_found <= 1'b0;
    end else if (cmd.scan2) begin
      low_found <= |grp_any;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan2) begin
      low_idx <= {grp_sel, grp_low[grp_sel]};
    end
  end

  assign send_slot_c = low_found ? low_idx : next_pos;
  assign ack_c       = low_found ? cfg.seq_gap + {{(SEQ_W-PTR_W){1'b0}}, low_idx}
                                 : expected_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tuser <= outcome;
      m_tdata <= {start_pos, end_pos - next_pos, end_pos - send_slot_c, send_slot_c, ack_c};
    end
  end

endmodule

// ----- rtl/selective_repeat_window_tracker_top.sv -----
// channel  dir  handshake            payload
// s        in   s_tvalid / s_tready  tuser: action; tdata: seq, slot, size
// m        out  m_tvalid / m_tready  tuser: outcome; tdata: ack_seq .. start_slot
// apb      in   psel/penable/pready  0x0 seq_gap, 0x4 window_limit
//
// Each item goes through accept, update, a two-level lowest-lost search over the flop bitmap
// and result load, in that order; no new item is accepted before that load.
// rst is synchronous; it clears pointers, the lost bitmap and the output valid.
// A new item is taken while the previous result waits; its result waits for m_tready.
module selective_repeat_window_tracker_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [srwt_pkg::IN_DATA_W-1:0]  s_tdata,  // seq[31:0], slot[39:32], size[48:40]
  input  logic [srwt_pkg::ACT_W-1:0]      s_tuser,  // action[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [srwt_pkg::OUT_DATA_W-1:0] m_tdata,  // ack_seq[31:0], send_slot[39:32],
                                                    // send_window[47:40], window[55:48],
                                                    // start_slot[63:56]
  output logic [2:0]                      m_tuser,  // outcome[2:0]
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srwt_pkg::ADDR_W-1:0]     paddr,
  input  logic [srwt_pkg::BUS_W-1:0]      pwdata,
  output logic [srwt_pkg::BUS_W-1:0]      prdata,
  output logic                            pready
);
  import srwt_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  srwt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srwt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srwt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
